// File: rtl/core/event_report_filter_counter_assert.svh
// event_report_filter_counter_assert.svh: assertion macros for the event report filter
// expects clk and rst in the scope of the module that uses them
`ifndef EVENT_REPORT_FILTER_COUNTER_ASSERT_SVH
`define EVENT_REPORT_FILTER_COUNTER_ASSERT_SVH

// same-cycle implication
`define ERFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ERFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/erfc_pkg.sv
// erfc_pkg: codes, states and controller/datapath link types of the event report filter
// no dependencies
`default_nettype none

package erfc_pkg;

  localparam int ID_W      = 6;
  localparam int OUT_CNT_W = 16;

  typedef enum logic [2:0] {
    OP_RAISE   = 3'd0,
    OP_ENABLE  = 3'd1,
    OP_DISABLE = 3'd2,
    OP_LIST    = 3'd3,
    OP_SET_SEV = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_INFO   = 3'd1,
    KIND_LOW    = 3'd2,
    KIND_MEDIUM = 3'd3,
    KIND_HIGH   = 3'd4,
    KIND_HEADER = 3'd5,
    KIND_ENTRY  = 3'd6,
    KIND_ERROR  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BAD_ID = 2'd1,
    ERR_BAD_OP = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    SEV_INFO   = 2'd0,
    SEV_LOW    = 2'd1,
    SEV_MEDIUM = 2'd2,
    SEV_HIGH   = 2'd3
  } sev_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ERR_OP,
    EMIT_ERR_ID,
    EMIT_HEADER,
    EMIT_ENTRY,
    EMIT_APPLY
  } emit_t;

  typedef struct packed {
    logic  take;
    logic  scan_rd;
    logic  scan_init;
    logic  scan_step;
    emit_t emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic accepted;
    logic op_unknown;
    logic op_list;
    logic id_bad;
    logic none_disabled;
    logic entry_disabled;
    logic last_entry;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/erfc_channels.sv
// erfc_channels: request and result channel interfaces of the event report filter
// no dependencies
`default_nettype none

interface erfc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] event_number;
  logic [1:0]  severity_value;

  modport source (output valid, operation, event_number, severity_value, input ready);
  modport sink (input valid, operation, event_number, severity_value, output ready);
endinterface

interface erfc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  report_kind;
  logic [1:0]  error_code;
  logic [5:0]  reported_id;
  logic [5:0]  list_count;
  logic [15:0] severity_event_count;
  logic [15:0] severity_report_count;
  logic [5:0]  severity_last_id;
  logic [5:0]  disabled_total;
  logic        last_item;

  modport source (
    output valid, report_kind, error_code, reported_id, list_count, severity_event_count,
           severity_report_count, severity_last_id, disabled_total, last_item,
    input  ready
  );
  modport sink (
    input  valid, report_kind, error_code, reported_id, list_count, severity_event_count,
           severity_report_count, severity_last_id, disabled_total, last_item,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/erfc_ctrl.sv
// erfc_ctrl: request sequencer of the event report filter
// depends on erfc_pkg
`default_nettype none

module erfc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire erfc_pkg::dp_stat_t stat,
  output erfc_pkg::ctl_cmd_t     cmd
);

  erfc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      erfc_pkg::ST_IDLE: begin
        if (stat.accepted) state_next = erfc_pkg::ST_EXEC;
      end
      erfc_pkg::ST_EXEC: begin
        if (stat.out_free) begin
          if (stat.op_list && !stat.op_unknown && !stat.none_disabled) begin
            state_next = erfc_pkg::ST_SCAN_RD;
          end else begin
            state_next = erfc_pkg::ST_IDLE;
          end
        end
      end
      erfc_pkg::ST_SCAN_RD: begin
        state_next = erfc_pkg::ST_SCAN_CHK;
      end
      erfc_pkg::ST_SCAN_CHK: begin
        if (!stat.entry_disabled) begin
          state_next = erfc_pkg::ST_SCAN_RD;
        end else if (stat.out_free) begin
          state_next = stat.last_entry ? erfc_pkg::ST_IDLE : erfc_pkg::ST_SCAN_RD;
        end
      end
      default: state_next = erfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{take: 1'b0, scan_rd: 1'b0, scan_init: 1'b0, scan_step: 1'b0,
            emit: erfc_pkg::EMIT_NONE};
    case (state)
      erfc_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
      end
      erfc_pkg::ST_EXEC: begin
        if (stat.out_free) begin
          if (stat.op_unknown) begin
            cmd.emit = erfc_pkg::EMIT_ERR_OP;
          end else if (stat.op_list) begin
            cmd.emit      = erfc_pkg::EMIT_HEADER;
            cmd.scan_init = 1'b1;
          end else if (stat.id_bad) begin
            cmd.emit = erfc_pkg::EMIT_ERR_ID;
          end else begin
            cmd.emit = erfc_pkg::EMIT_APPLY;
          end
        end
      end
      erfc_pkg::ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
      end
      erfc_pkg::ST_SCAN_CHK: begin
        if (!stat.entry_disabled) begin
          cmd.scan_step = 1'b1;
        end else if (stat.out_free) begin
          cmd.emit      = erfc_pkg::EMIT_ENTRY;
          cmd.scan_step = 1'b1;
        end
      end
      default: cmd.take = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/erfc_datapath.sv
// erfc_datapath: event table, severity counters, list scan and result register
// depends on erfc_pkg, erfc_channels and event_report_filter_counter_assert.svh
`default_nettype none
`include "event_report_filter_counter_assert.svh"

module erfc_datapath #(
  parameter int EVENT_COUNT   = 63,
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire erfc_pkg::ctl_cmd_t cmd,
  output erfc_pkg::dp_stat_t      stat,
  erfc_req_if.sink                req,
  erfc_rsp_if.source              rsp
);

  localparam int DEPTH = EVENT_COUNT + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = erfc_pkg::ID_W;
  localparam int OW    = erfc_pkg::OUT_CNT_W;

  // captured request
  logic [2:0]    op_q;
  logic [IW-1:0] id_q;
  logic [1:0]    sev_q;
  logic          id_bad_q;

  // event table: {disabled, severity}; an entry never written reads as enabled, informative
  logic [2:0]       ent_mem [DEPTH];
  logic [DEPTH-1:0] ent_vld;
  logic [2:0]       rd_raw;
  logic             rd_vld;
  logic [2:0]       rd_ent;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [2:0]       wr_data;

  logic [COUNTER_WIDTH-1:0] ev_cnt  [3];
  logic [COUNTER_WIDTH-1:0] rp_cnt  [3];
  logic [IW-1:0]            last_id [3];
  logic [5:0]               dis_cnt, dis_cnt_next;
  logic [5:0]               remaining;
  logic [AW-1:0]            scan_idx;

  logic                     accepted;
  logic                     ent_dis;
  logic [1:0]               ent_sev;
  logic                     sev_nz;
  logic [1:0]               sidx;
  logic [COUNTER_WIDTH-1:0] ec_new, rc_inc, rc_out;
  logic [IW-1:0]            lid_out;
  logic                     is_raise, cnt_upd;

  logic          out_valid;
  logic [2:0]    o_kind;
  logic [1:0]    o_err;
  logic [IW-1:0] o_id, o_lc, o_lid, o_dis;
  logic [OW-1:0] o_ec, o_rc;
  logic          o_last;

  assign accepted  = cmd.take && req.valid;
  assign req.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (accepted) begin
      op_q     <= req.operation;
      id_q     <= req.event_number[IW-1:0];
      sev_q    <= req.severity_value;
      id_bad_q <= (req.event_number == 16'd0) || (req.event_number > 16'(EVENT_COUNT));
    end
  end

  // single read port: request id at accept, scan index during a list
  assign rd_addr = cmd.scan_rd ? scan_idx : req.event_number[AW-1:0];
  assign rd_en   = accepted || cmd.scan_rd;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= ent_mem[rd_addr];
      rd_vld <= ent_vld[rd_addr];
    end
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (wr_en) begin
      ent_vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_ent  = rd_vld ? rd_raw : 3'b000;
  assign ent_dis = rd_ent[2];
  assign ent_sev = rd_ent[1:0];
  assign sev_nz  = (ent_sev != erfc_pkg::SEV_INFO);
  assign sidx    = ent_sev - 2'd1;

  assign is_raise = (op_q == erfc_pkg::OP_RAISE);
  assign cnt_upd  = (cmd.emit == erfc_pkg::EMIT_APPLY) && is_raise && sev_nz;
  assign ec_new   = ev_cnt[sidx] + COUNTER_WIDTH'(1);
  assign rc_inc   = rp_cnt[sidx] + COUNTER_WIDTH'(1);
  assign rc_out   = ent_dis ? rp_cnt[sidx] : rc_inc;
  assign lid_out  = ent_dis ? last_id[sidx] : id_q;

  // table write and disabled count for enable, disable and set severity
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = id_q[AW-1:0];
    wr_data      = rd_ent;
    dis_cnt_next = dis_cnt;
    if (cmd.emit == erfc_pkg::EMIT_APPLY) begin
      case (op_q)
        erfc_pkg::OP_ENABLE: begin
          wr_en   = 1'b1;
          wr_data = {1'b0, ent_sev};
          if (ent_dis) dis_cnt_next = dis_cnt - 6'd1;
        end
        erfc_pkg::OP_DISABLE: begin
          wr_en   = 1'b1;
          wr_data = {1'b1, ent_sev};
          if (!ent_dis) dis_cnt_next = dis_cnt + 6'd1;
        end
        erfc_pkg::OP_SET_SEV: begin
          wr_en   = 1'b1;
          wr_data = {ent_dis, sev_q};
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 3; s++) begin
        ev_cnt[s]  <= '0;
        rp_cnt[s]  <= '0;
        last_id[s] <= '0;
      end
      dis_cnt <= '0;
    end else begin
      dis_cnt <= dis_cnt_next;
      if (cnt_upd) begin
        ev_cnt[sidx] <= ec_new;
        if (!ent_dis) begin
          rp_cnt[sidx]  <= rc_inc;
          last_id[sidx] <= id_q;
        end
      end
    end
  end

  // list scan
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      remaining <= dis_cnt;
      scan_idx  <= AW'(1);
    end else begin
      if (cmd.emit == erfc_pkg::EMIT_ENTRY) remaining <= remaining - 6'd1;
      if (cmd.scan_step) scan_idx <= scan_idx + AW'(1);
    end
  end

  // next result
  always_comb begin
    o_kind = erfc_pkg::KIND_NONE;
    o_err  = erfc_pkg::ERR_NONE;
    o_id   = '0;
    o_lc   = '0;
    o_ec   = '0;
    o_rc   = '0;
    o_lid  = '0;
    o_dis  = dis_cnt;
    o_last = 1'b1;
    case (cmd.emit)
      erfc_pkg::EMIT_ERR_OP: begin
        o_kind = erfc_pkg::KIND_ERROR;
        o_err  = erfc_pkg::ERR_BAD_OP;
      end
      erfc_pkg::EMIT_ERR_ID: begin
        o_kind = erfc_pkg::KIND_ERROR;
        o_err  = erfc_pkg::ERR_BAD_ID;
      end
      erfc_pkg::EMIT_HEADER: begin
        o_kind = erfc_pkg::KIND_HEADER;
        o_lc   = dis_cnt;
        o_last = (dis_cnt == 6'd0);
      end
      erfc_pkg::EMIT_ENTRY: begin
        o_kind = erfc_pkg::KIND_ENTRY;
        o_id   = IW'(scan_idx);
        o_last = (remaining == 6'd1);
      end
      erfc_pkg::EMIT_APPLY: begin
        o_dis = dis_cnt_next;
        if (is_raise && !ent_dis) begin
          o_kind = 3'({1'b0, ent_sev}) + 3'd1;
          o_id   = id_q;
        end
        if (is_raise && sev_nz) begin
          o_ec  = OW'(ec_new);
          o_rc  = OW'(rc_out);
          o_lid = lid_out;
        end
      end
      default: o_last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != erfc_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != erfc_pkg::EMIT_NONE) begin
      rsp.report_kind           <= o_kind;
      rsp.error_code            <= o_err;
      rsp.reported_id           <= o_id;
      rsp.list_count            <= o_lc;
      rsp.severity_event_count  <= o_ec;
      rsp.severity_report_count <= o_rc;
      rsp.severity_last_id      <= o_lid;
      rsp.disabled_total        <= o_dis;
      rsp.last_item             <= o_last;
    end
  end

  assign rsp.valid = out_valid;

  assign stat = '{
    accepted:       accepted,
    op_unknown:     (op_q > erfc_pkg::OP_SET_SEV),
    op_list:        (op_q == erfc_pkg::OP_LIST),
    id_bad:         id_bad_q,
    none_disabled:  (dis_cnt == 6'd0),
    entry_disabled: ent_dis,
    last_entry:     (remaining == 6'd1),
    out_free:       (!out_valid || rsp.ready)
  };

  `ERFC_ASSERT_NOW(a_no_overwrite, out_valid && !rsp.ready, cmd.emit == erfc_pkg::EMIT_NONE, "pending result overwritten")
  `ERFC_ASSERT_NOW(a_dis_range, 1'b1, dis_cnt <= 6'(EVENT_COUNT), "disabled count out of range")
  `ERFC_ASSERT_NOW(a_entry_valid, cmd.emit == erfc_pkg::EMIT_ENTRY, remaining != 6'd0 && ent_dis, "list entry beyond disabled count")
  `ERFC_ASSERT_NEXT(a_one_request, accepted, !req.ready, "request taken while one in flight")

endmodule

`default_nettype wire

// File: rtl/core/event_report_filter_counter.sv
// event report filter: raise/enable/disable/list/set-severity requests, one at a time.
// a request is taken in idle and decided in exec, where its result is registered once the
// output is free; list entries follow the header, each scanned id taking a read and a check
// state, set by the single read port of the event table; the next request waits for idle.
// reset clears counters, disabled count and table valid bits at once; no clearing pass.
// depends on erfc_pkg, erfc_channels, erfc_ctrl, erfc_datapath
`default_nettype none

module event_report_filter_counter #(
  parameter int EVENT_COUNT   = 63,
  parameter int COUNTER_WIDTH = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  erfc_req_if.sink   req,
  erfc_rsp_if.source rsp
);

  erfc_pkg::ctl_cmd_t cmd;
  erfc_pkg::dp_stat_t stat;

  erfc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  erfc_datapath #(
    .EVENT_COUNT   (EVENT_COUNT),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

// File: verif/tb_event_report_filter_counter.sv
// tb_event_report_filter_counter: self-checking bench for the event report filter and counter
// drives requests with random gaps, predicts every report and compares field by field
// depends on erfc_pkg, erfc_channels and event_report_filter_counter
`default_nettype none

module tb_event_report_filter_counter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EVENT_COUNT   = 63;
  localparam int COUNTER_WIDTH = 16;
  localparam int RANDOM_ITEMS  = 150;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] num;
    logic [1:0]  sev;
  } request_t;

  typedef struct packed {
    erfc_pkg::kind_t kind;
    erfc_pkg::err_t  err;
    logic [5:0]      id;
    logic [5:0]      lcount;
    logic [15:0]     ev_cnt;
    logic [15:0]     rep_cnt;
    logic [5:0]      last_id;
    logic [5:0]      dis_total;
    logic            last;
  } report_t;

  logic clk;
  logic rst;

  erfc_req_if request_bus ();
  erfc_rsp_if report_bus ();

  event_report_filter_counter #(
    .EVENT_COUNT  (EVENT_COUNT),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(request_bus),
    .rsp(report_bus)
  );

  request_t pending_requests[$];
  report_t  expected_reports[$];
  int       requests_offered;
  int       requests_taken;
  int       reports_seen;
  int       mismatches;
  int       cycle_count;
  int       send_gap;
  int       stall_left;

  // shadow of the filter state
  logic           event_enabled [1:EVENT_COUNT];
  erfc_pkg::sev_t severity_of   [1:EVENT_COUNT];
  logic [15:0]    raised_cnt    [4];
  logic [15:0]    reported_cnt  [4];
  logic [5:0]     last_id_of    [4];
  logic [5:0]     disabled_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_request(input logic [2:0] op, input logic [15:0] num,
                               input logic [1:0] sev);
    request_t r;
    r.op  = op;
    r.num = num;
    r.sev = sev;
    pending_requests.push_back(r);
  endtask

  task automatic predict_request(input request_t r);
    report_t        rep;
    logic [5:0]     idx;
    logic [5:0]     remaining;
    erfc_pkg::sev_t s;
    logic           en;
    rep = '0;
    rep.last = 1'b1;
    if (r.op > erfc_pkg::OP_SET_SEV) begin
      rep.kind = erfc_pkg::KIND_ERROR;
      rep.err  = erfc_pkg::ERR_BAD_OP;
    end else if (r.op == erfc_pkg::OP_LIST) begin
      rep.kind = erfc_pkg::KIND_HEADER;
      rep.lcount = disabled_count;
      rep.last = (disabled_count == 0);
      remaining = disabled_count;
      for (int i = 1; i <= EVENT_COUNT; i++) begin
        if (!event_enabled[i]) begin
          rep.dis_total = disabled_count;
          expected_reports.push_back(rep);
          remaining = remaining - 1'b1;
          rep = '0;
          rep.kind = erfc_pkg::KIND_ENTRY;
          rep.id = i[5:0];
          rep.last = (remaining == 0);
        end
      end
    end else if (r.num == 0 || r.num > EVENT_COUNT) begin
      rep.kind = erfc_pkg::KIND_ERROR;
      rep.err  = erfc_pkg::ERR_BAD_ID;
    end else begin
      idx = r.num[5:0];
      if (r.op == erfc_pkg::OP_ENABLE || r.op == erfc_pkg::OP_DISABLE) begin
        en = (r.op == erfc_pkg::OP_ENABLE);
        if (event_enabled[idx] != en) begin
          event_enabled[idx] = en;
          disabled_count = en ? disabled_count - 1'b1 : disabled_count + 1'b1;
        end
      end else if (r.op == erfc_pkg::OP_SET_SEV) begin
        severity_of[idx] = erfc_pkg::sev_t'(r.sev);
      end else begin
        s  = severity_of[idx];
        en = event_enabled[idx];
        rep.id = en ? idx : '0;
        if (s == erfc_pkg::SEV_INFO) begin
          rep.kind = en ? erfc_pkg::KIND_INFO : erfc_pkg::KIND_NONE;
        end else begin
          raised_cnt[s] = raised_cnt[s] + 1'b1;
          if (en) begin
            reported_cnt[s] = reported_cnt[s] + 1'b1;
            last_id_of[s] = idx;
          end
          case (s)
            erfc_pkg::SEV_LOW:    rep.kind = en ? erfc_pkg::KIND_LOW : erfc_pkg::KIND_NONE;
            erfc_pkg::SEV_MEDIUM: rep.kind = en ? erfc_pkg::KIND_MEDIUM : erfc_pkg::KIND_NONE;
            default:              rep.kind = en ? erfc_pkg::KIND_HIGH : erfc_pkg::KIND_NONE;
          endcase
          rep.ev_cnt  = raised_cnt[s];
          rep.rep_cnt = reported_cnt[s];
          rep.last_id = last_id_of[s];
        end
      end
    end
    rep.dis_total = disabled_count;
    expected_reports.push_back(rep);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      request_bus.valid <= 1'b0;
      request_bus.operation <= '0;
      request_bus.event_number <= '0;
      request_bus.severity_value <= '0;
      send_gap = 0;
    end else if (!request_bus.valid || requests_taken == requests_offered) begin
      if (send_gap > 0) begin
        request_bus.valid <= 1'b0;
        send_gap--;
      end else if (pending_requests.size() != 0) begin
        request_bus.valid <= 1'b1;
        request_bus.operation <= pending_requests[0].op;
        request_bus.event_number <= pending_requests[0].num;
        request_bus.severity_value <= pending_requests[0].sev;
        requests_offered++;
        send_gap = pick_gap((requests_offered / 16) % 4 == 3);
      end else begin
        request_bus.valid <= 1'b0;
      end
    end
  end

  // report sink stalls
  always @(negedge clk) begin
    if (rst) begin
      report_bus.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      report_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      report_bus.ready <= 1'b1;
      stall_left = pick_gap((reports_seen / 24) % 4 == 1);
    end
  end

  // request acceptance and report checking
  always @(posedge clk) begin
    report_t exp_rep;
    if (!rst && request_bus.valid && request_bus.ready) begin
      predict_request(pending_requests.pop_front());
      requests_taken++;
    end
    if (!rst && report_bus.valid && report_bus.ready) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, kind %0d id %0d", $time,
                 report_bus.report_kind, report_bus.reported_id);
        mismatches++;
      end else begin
        exp_rep = expected_reports.pop_front();
        check_field("report_kind", exp_rep.kind, report_bus.report_kind);
        check_field("error_code", exp_rep.err, report_bus.error_code);
        check_field("reported_id", exp_rep.id, report_bus.reported_id);
        check_field("list_count", exp_rep.lcount, report_bus.list_count);
        check_field("severity_event_count", exp_rep.ev_cnt, report_bus.severity_event_count);
        check_field("severity_report_count", exp_rep.rep_cnt,
                    report_bus.severity_report_count);
        check_field("severity_last_id", exp_rep.last_id, report_bus.severity_last_id);
        check_field("disabled_total", exp_rep.dis_total, report_bus.disabled_total);
        check_field("last_item", exp_rep.last, report_bus.last_item);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int         r;
    logic [2:0] op;
    logic [15:0] num;

    rst = 1'b1;
    request_bus.valid = 1'b0;
    request_bus.operation = '0;
    request_bus.event_number = '0;
    request_bus.severity_value = '0;
    report_bus.ready = 1'b0;
    requests_offered = 0;
    requests_taken = 0;
    reports_seen = 0;
    mismatches = 0;
    cycle_count = 0;
    send_gap = 0;
    stall_left = 0;
    disabled_count = '0;
    for (int i = 1; i <= EVENT_COUNT; i++) begin
      event_enabled[i] = 1'b1;
      severity_of[i] = erfc_pkg::SEV_INFO;
    end
    for (int i = 0; i < 4; i++) begin
      raised_cnt[i] = '0;
      reported_cnt[i] = '0;
      last_id_of[i] = '0;
    end

    // directed: bad ids and ops, empty list, every severity, disabled raises
    queue_request(erfc_pkg::OP_RAISE, 16'd5, erfc_pkg::SEV_HIGH);
    queue_request(erfc_pkg::OP_RAISE, 16'd0, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_ENABLE, 16'd64, erfc_pkg::SEV_LOW);
    queue_request(erfc_pkg::OP_DISABLE, 16'hffff, erfc_pkg::SEV_HIGH);
    queue_request(erfc_pkg::OP_SET_SEV, 16'd0, erfc_pkg::SEV_HIGH);
    queue_request(3'd5, 16'd1, erfc_pkg::SEV_LOW);
    queue_request(3'd6, 16'hffff, erfc_pkg::SEV_HIGH);
    queue_request(3'd7, 16'd63, erfc_pkg::SEV_MEDIUM);
    queue_request(erfc_pkg::OP_LIST, 16'd0, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_SET_SEV, 16'd1, erfc_pkg::SEV_LOW);
    queue_request(erfc_pkg::OP_SET_SEV, 16'd63, erfc_pkg::SEV_HIGH);
    queue_request(erfc_pkg::OP_SET_SEV, 16'd32, erfc_pkg::SEV_MEDIUM);
    queue_request(erfc_pkg::OP_RAISE, 16'd1, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_RAISE, 16'd63, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_RAISE, 16'd32, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_DISABLE, 16'd63, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_DISABLE, 16'd1, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_DISABLE, 16'd1, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_RAISE, 16'd63, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_LIST, 16'hffff, erfc_pkg::SEV_HIGH);
    queue_request(erfc_pkg::OP_ENABLE, 16'd63, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_ENABLE, 16'd63, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_SET_SEV, 16'd1, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_RAISE, 16'd1, erfc_pkg::SEV_INFO);
    queue_request(erfc_pkg::OP_LIST, 16'd0, erfc_pkg::SEV_INFO);

    // random traffic, disables a bit more likely than enables so lists grow
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = erfc_pkg::OP_RAISE;
      else if (r < 56) op = erfc_pkg::OP_ENABLE;
      else if (r < 72) op = erfc_pkg::OP_DISABLE;
      else if (r < 80) op = erfc_pkg::OP_LIST;
      else if (r < 95) op = erfc_pkg::OP_SET_SEV;
      else op = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      if (r < 3) num = 16'd0;
      else if (r < 8) num = 16'($urandom_range(64, 65535));
      else if (r < 50) num = 16'($urandom_range(1, 8));
      else num = 16'($urandom_range(1, EVENT_COUNT));
      queue_request(op, num, 2'($urandom_range(0, 3)));
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_requests.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
